FILE: rtl/pdm_pkg.sv
// Shared types and constants for the PCM downmix nibble packer.
package pdm_pkg;

    localparam int LANES        = 8;
    localparam int MAX_CHANNELS = 8;
    localparam int SAMPLE_W     = 16;
    localparam int SUM_W        = 19;
    localparam int CNT_W        = 4;
    localparam int DIV_STEPS    = 19;
    localparam int DIV_CNT_W    = 5;
    localparam int MERGE_LAT    = 3;
    localparam int MERGE_CNT_W  = 2;

    localparam logic [7:0] ZERO_SUB = 8'h11;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    typedef struct packed {
        logic signed [15:0] chan0_sample;
        logic signed [15:0] chan1_sample;
        logic signed [15:0] chan2_sample;
        logic signed [15:0] chan3_sample;
        logic signed [15:0] chan4_sample;
        logic signed [15:0] chan5_sample;
        logic signed [15:0] chan6_sample;
        logic signed [15:0] chan7_sample;
        logic               final_frame;
    } t_in;

    typedef struct packed {
        logic [7:0] packed_byte;
        logic       end_marker;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_START,
        S_DIV,
        S_PACK,
        S_TERM
    } t_state;

endpackage

FILE: rtl/pcm_downmix_4bit_packer_top.sv
// Top level of the PCM downmix 4-bit packer: lanes, merge tree, divider, packer.
//
// Channel | Direction | Signals                              | Beat taken when
// --------+-----------+--------------------------------------+------------------------------
// in      | in        | i_in_valid, i_in_data, o_in_stall    | i_in_valid && !o_in_stall
// out     | out       | o_out_valid, o_out_data, i_out_stall | o_out_valid && !i_out_stall
// cfg     | in        | i_cfg_we, i_cfg_data                 | i_cfg_we
//
// Each frame is loaded into the lanes, summed in the adder tree, launched into the
// divider, divided (19 quotient bits one a cycle, then done) and packed; the next
// frame is taken only back in idle. A final frame adds a terminator beat.
// Reset (synchronous, active low) clears the pair state and the output
// valid flag and sets the channel count to 2. A stalled output holds its beat;
// the next frame is still taken while one beat waits in the output register.
module pcm_downmix_4bit_packer_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  pdm_pkg::t_in              i_in_data,
    output logic                      o_in_stall,
    output logic                      o_out_valid,
    output pdm_pkg::t_out             o_out_data,
    input  logic                      i_out_stall,
    input  logic                      i_cfg_we,
    input  logic [pdm_pkg::CNT_W-1:0] i_cfg_data
);

    pdm_pkg::t_state r_state, n_state;

    logic [pdm_pkg::CNT_W-1:0]       r_chan_cnt;
    logic [pdm_pkg::MERGE_CNT_W-1:0] r_cnt;
    logic                            r_final;
    logic                            r_half;
    logic [3:0]                      r_low;
    logic                            r_out_valid;
    pdm_pkg::t_out                   r_out_data;

    // Effective channel count: zero acts as one, above the limit saturates.
    logic [pdm_pkg::CNT_W-1:0] w_nch;
    pdm_pkg::t_sample [pdm_pkg::LANES-1:0] w_in_samples;
    pdm_pkg::t_sample [pdm_pkg::LANES-1:0] w_lane_out;
    logic signed [pdm_pkg::SUM_W-1:0] w_sum;
    logic                             w_div_done;
    logic signed [15:0]               w_mean;
    logic [3:0]                       w_level;
    logic [7:0]                       w_byte_raw;
    logic [7:0]                       w_byte;

    logic w_lane_load;
    logic w_div_start;
    logic w_out_free;
    logic w_emit;
    logic w_hold;
    logic w_pack_load;
    logic w_term_load;

    assign w_nch = (r_chan_cnt == '0) ? pdm_pkg::CNT_W'(1)
                 : (r_chan_cnt > pdm_pkg::CNT_W'(pdm_pkg::MAX_CHANNELS))
                   ? pdm_pkg::CNT_W'(pdm_pkg::MAX_CHANNELS) : r_chan_cnt;

    assign w_in_samples[0] = i_in_data.chan0_sample;
    assign w_in_samples[1] = i_in_data.chan1_sample;
    assign w_in_samples[2] = i_in_data.chan2_sample;
    assign w_in_samples[3] = i_in_data.chan3_sample;
    assign w_in_samples[4] = i_in_data.chan4_sample;
    assign w_in_samples[5] = i_in_data.chan5_sample;
    assign w_in_samples[6] = i_in_data.chan6_sample;
    assign w_in_samples[7] = i_in_data.chan7_sample;

    // Channel lanes
    for (genvar k = 0; k < pdm_pkg::LANES; k++) begin : g_lane
        pdm_lane u_lane (
            .i_clk    (i_clk),
            .i_load   (w_lane_load),
            .i_active (pdm_pkg::CNT_W'(k) < w_nch),
            .i_sample (w_in_samples[k]),
            .o_sample (w_lane_out[k])
        );
    end

    pdm_merge u_merge (
        .i_clk   (i_clk),
        .i_lanes (w_lane_out),
        .o_sum   (w_sum)
    );

    pdm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_sum),
        .i_divisor  (w_nch),
        .o_done     (w_div_done),
        .o_quotient (w_mean)
    );

    // floor(mean / 4096) + 8, kept to 4 bits: flip the sign bit of mean[15:12].
    assign w_level    = {~w_mean[15], w_mean[14:12]};
    assign w_byte_raw = r_half ? {w_level, r_low} : {w_level, w_level};
    assign w_byte     = (w_byte_raw == '0) ? pdm_pkg::ZERO_SUB : w_byte_raw;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_emit     = r_half || r_final;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pdm_pkg::S_IDLE: begin
                if (i_in_valid) n_state = pdm_pkg::S_SUM;
            end
            pdm_pkg::S_SUM: begin
                if (r_cnt == pdm_pkg::MERGE_CNT_W'(pdm_pkg::MERGE_LAT - 1)) begin
                    n_state = pdm_pkg::S_START;
                end
            end
            pdm_pkg::S_START: begin
                n_state = pdm_pkg::S_DIV;
            end
            pdm_pkg::S_DIV: begin
                if (w_div_done) n_state = pdm_pkg::S_PACK;
            end
            pdm_pkg::S_PACK: begin
                if (!w_emit) begin
                    n_state = pdm_pkg::S_IDLE;
                end else if (w_out_free) begin
                    n_state = r_final ? pdm_pkg::S_TERM : pdm_pkg::S_IDLE;
                end
            end
            pdm_pkg::S_TERM: begin
                if (w_out_free) n_state = pdm_pkg::S_IDLE;
            end
            default: n_state = pdm_pkg::S_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_in_stall  = 1'b1;
        w_lane_load = 1'b0;
        w_div_start = 1'b0;
        w_hold      = 1'b0;
        w_pack_load = 1'b0;
        w_term_load = 1'b0;
        case (r_state)
            pdm_pkg::S_IDLE: begin
                o_in_stall  = 1'b0;
                w_lane_load = i_in_valid;
            end
            pdm_pkg::S_START: begin
                w_div_start = 1'b1;
            end
            pdm_pkg::S_PACK: begin
                w_hold      = !w_emit;
                w_pack_load = w_emit && w_out_free;
            end
            pdm_pkg::S_TERM: begin
                w_term_load = w_out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pdm_pkg::S_IDLE;
            r_chan_cnt  <= pdm_pkg::CNT_W'(2);
            r_cnt       <= '0;
            r_half      <= 1'b0;
            r_low       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_chan_cnt <= i_cfg_data;

            if (r_state == pdm_pkg::S_SUM) begin
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_cnt <= '0;
            end

            // Pair state: hold first level, clear once the byte goes out.
            if (w_hold) begin
                r_low  <= w_level;
                r_half <= 1'b1;
            end else if (w_pack_load) begin
                r_low  <= '0;
                r_half <= 1'b0;
            end

            if (w_pack_load || w_term_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_lane_load) r_final <= i_in_data.final_frame;
        if (w_pack_load) begin
            r_out_data.packed_byte <= w_byte;
            r_out_data.end_marker  <= 1'b0;
        end else if (w_term_load) begin
            r_out_data.packed_byte <= '0;
            r_out_data.end_marker  <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Divider finishes only while the controller waits for it.
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == pdm_pkg::S_DIV))
        else $error("divider done outside wait state");

    // A data beat never carries the zero byte reserved for the terminator.
    a_no_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.end_marker) |-> (o_out_data.packed_byte != '0))
        else $error("zero data byte");

    // The terminator is always the zero byte.
    a_term_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.end_marker) |-> (o_out_data.packed_byte == '0))
        else $error("terminator not zero");

    // Pair state is clear once the final frame's data byte has gone out.
    a_term_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pdm_pkg::S_TERM) |-> !r_half)
        else $error("pending nibble at terminator");

endmodule

FILE: rtl/pdm_lane.sv
// One channel lane: masks an inactive channel to zero and registers the sample.
module pdm_lane (
    input  logic             i_clk,
    input  logic             i_load,
    input  logic             i_active,
    input  pdm_pkg::t_sample i_sample,
    output pdm_pkg::t_sample o_sample
);

    pdm_pkg::t_sample r_sample;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sample <= i_active ? i_sample : '0;
        end
    end

    assign o_sample = r_sample;

endmodule

FILE: rtl/pdm_merge.sv
// Registered three-level adder tree that sums the lane samples.
module pdm_merge (
    input  logic                                   i_clk,
    input  pdm_pkg::t_sample [pdm_pkg::LANES-1:0]  i_lanes,
    output logic signed [pdm_pkg::SUM_W-1:0]       o_sum
);

    logic signed [16:0] r_l1 [4];
    logic signed [17:0] r_l2 [2];
    logic signed [18:0] r_l3;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            r_l1[k] <= 17'($signed(i_lanes[2*k])) + 17'($signed(i_lanes[2*k+1]));
        end
        for (int k = 0; k < 2; k++) begin
            r_l2[k] <= 18'(r_l1[2*k]) + 18'(r_l1[2*k+1]);
        end
        r_l3 <= 19'(r_l2[0]) + 19'(r_l2[1]);
    end

    assign o_sum = r_l3;

endmodule

FILE: rtl/pdm_div.sv
// Bit-serial restoring divider: signed sum by channel count, truncating toward zero.
module pdm_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic signed [pdm_pkg::SUM_W-1:0] i_dividend,
    input  logic [pdm_pkg::CNT_W-1:0]        i_divisor,
    output logic                             o_done,
    output logic signed [15:0]               o_quotient
);

    logic [pdm_pkg::SUM_W-1:0]     r_quo;
    logic [pdm_pkg::CNT_W-1:0]     r_rem;
    logic [pdm_pkg::CNT_W-1:0]     r_div;
    logic                          r_neg;
    logic                          r_busy;
    logic                          r_done;
    logic [pdm_pkg::DIV_CNT_W-1:0] r_cnt;

    logic [pdm_pkg::SUM_W-1:0] w_mag;
    logic [pdm_pkg::CNT_W:0]   w_trial;
    logic                      w_ge;
    logic [pdm_pkg::SUM_W-1:0] w_signed_q;

    assign w_mag   = i_dividend[pdm_pkg::SUM_W-1]
                     ? pdm_pkg::SUM_W'(~i_dividend + 1'b1)
                     : pdm_pkg::SUM_W'(i_dividend);
    assign w_trial = {r_rem, r_quo[pdm_pkg::SUM_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == pdm_pkg::DIV_CNT_W'(pdm_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= w_mag;
            r_rem <= '0;
            r_div <= i_divisor;
            r_neg <= i_dividend[pdm_pkg::SUM_W-1];
        end else if (r_busy) begin
            r_quo <= {r_quo[pdm_pkg::SUM_W-2:0], w_ge};
            r_rem <= w_ge ? pdm_pkg::CNT_W'(w_trial - {1'b0, r_div})
                          : w_trial[pdm_pkg::CNT_W-1:0];
        end
    end

    assign w_signed_q = r_neg ? pdm_pkg::SUM_W'(~r_quo + 1'b1) : r_quo;
    assign o_quotient = $signed(w_signed_q[15:0]);
    assign o_done     = r_done;

endmodule

FILE: bench/testbench.sv
// Self-checking bench for the PCM downmix 4-bit packer: directed table, then random clips.
`timescale 1ns / 1ps

module testbench;

    // Terminator beat that closes each clip
    localparam logic [7:0] TERM_BYTE = 8'h00;
    // Quiet time before a count write: a frame that is the first of a pair
    // makes no beat, so it may still be in the pipe after the last
    // expected beat has arrived.
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_FRAMES  = 200;
    localparam int RANDOM_PHASES = 7;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_in_valid;
    pdm_pkg::t_in   i_in_data;
    logic           o_in_stall;
    logic           o_out_valid;
    pdm_pkg::t_out  o_out_data;
    logic           i_out_stall;
    logic           i_cfg_we;
    logic  [pdm_pkg::CNT_W-1:0] i_cfg_data;

    pcm_downmix_4bit_packer_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    // One row of the directed table. A row may first change the channel
    // count; where the packed byte is obvious it is typed in, otherwise the
    // predictor supplies it.
    typedef struct {
        logic                      wr_cfg;
        logic [pdm_pkg::CNT_W-1:0] cfg_val;
        pdm_pkg::t_in              frame;
        logic                      typed;
        logic [7:0]                typed_byte;
    } t_frame_row;

    t_frame_row directed_rows[$];

    // Predictor state: channel count as last written, plus the held level
    // of an unpaired first frame.
    logic [pdm_pkg::CNT_W-1:0] mix_count;
    logic [3:0]                held_level;
    logic                      level_held;

    pdm_pkg::t_out expected_beats[$];
    int            mismatches;
    bit            quiet;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs
    initial begin
        #12_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Mean of the active channels (truncated toward zero), floor-shifted
    // by 12 and offset by 8.
    function automatic logic [3:0] downmix_level(pdm_pkg::t_in f,
                                                 logic [pdm_pkg::CNT_W-1:0] cnt);
        logic signed [15:0] lane [pdm_pkg::LANES];
        int n;
        int acc;
        int mean;
        lane = '{f.chan0_sample, f.chan1_sample, f.chan2_sample, f.chan3_sample,
                 f.chan4_sample, f.chan5_sample, f.chan6_sample, f.chan7_sample};
        n = (cnt == 0) ? 1 : int'(cnt);
        if (n > pdm_pkg::MAX_CHANNELS)
            n = pdm_pkg::MAX_CHANNELS;
        if (n > pdm_pkg::LANES)
            n = pdm_pkg::LANES;
        acc = 0;
        for (int k = 0; k < n; k++)
            acc += lane[k];
        mean = acc / n;
        return 4'((mean >>> 12) + 8);
    endfunction

    // Pair up levels into bytes and queue the beats a frame produces.
    function automatic void pack_frame(pdm_pkg::t_in f, logic typed, logic [7:0] typed_byte);
        logic [3:0] lvl;
        pdm_pkg::t_out beat;
        lvl = downmix_level(f, mix_count);
        if (!level_held && !f.final_frame) begin
            held_level = lvl;
            level_held = 1'b1;
            return;
        end
        // odd clip: a lone final frame repeats its level in both nibbles
        beat.packed_byte = level_held ? {lvl, held_level} : {lvl, lvl};
        if (beat.packed_byte == 8'h00)
            beat.packed_byte = pdm_pkg::ZERO_SUB;
        if (typed)
            beat.packed_byte = typed_byte;
        beat.end_marker = 1'b0;
        expected_beats.push_back(beat);
        level_held = 1'b0;
        held_level = 4'h0;
        if (f.final_frame) begin
            beat.packed_byte = TERM_BYTE;
            beat.end_marker  = 1'b1;
            expected_beats.push_back(beat);
        end
    endfunction

    function automatic pdm_pkg::t_in make_frame(int c0, int c1, int rest, logic fin);
        pdm_pkg::t_in f;
        f.chan0_sample = 16'(c0);
        f.chan1_sample = 16'(c1);
        f.chan2_sample = 16'(rest);
        f.chan3_sample = 16'(rest);
        f.chan4_sample = 16'(rest);
        f.chan5_sample = 16'(rest);
        f.chan6_sample = 16'(rest);
        f.chan7_sample = 16'(rest);
        f.final_frame  = fin;
        return f;
    endfunction

    function automatic void add_row(logic wr, logic [pdm_pkg::CNT_W-1:0] cv,
                                    pdm_pkg::t_in f, logic ty, logic [7:0] tb);
        directed_rows.push_back('{wr, cv, f, ty, tb});
    endfunction

    // Rails, small values near zero, values clustered around a common base
    // (so the mean lands anywhere in the level range), and plain noise.
    function automatic logic [15:0] random_sample(logic [15:0] base);
        case ($urandom_range(0, 9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'($urandom_range(0, 31)) - 16'd16;
            3, 4:    return base + 16'($urandom_range(0, 511)) - 16'd256;
            default: return 16'($urandom);
        endcase
    endfunction

    // Clips of random length: roughly one frame in eight closes a clip,
    // so odd and even clip lengths both come up often.
    function automatic pdm_pkg::t_in random_frame();
        pdm_pkg::t_in f;
        logic [15:0] base;
        base = 16'($urandom);
        f.chan0_sample = random_sample(base);
        f.chan1_sample = random_sample(base);
        f.chan2_sample = random_sample(base);
        f.chan3_sample = random_sample(base);
        f.chan4_sample = random_sample(base);
        f.chan5_sample = random_sample(base);
        f.chan6_sample = random_sample(base);
        f.chan7_sample = random_sample(base);
        f.final_frame  = ($urandom_range(0, 7) == 0);
        return f;
    endfunction

    // Called at a falling edge, returns at a falling edge. Valid is only
    // lowered when a gap is taken, so back-to-back beats keep it high.
    task automatic send_frame(pdm_pkg::t_in f, logic typed, logic [7:0] typed_byte);
        int gap;
        gap = quiet ? 0 : idle_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= f;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        pack_frame(f, typed, typed_byte);
        @(negedge i_clk);
    endtask

    // Count writes happen only with the block drained: every expected beat
    // out, then a settle window for a silent first-of-pair frame.
    task automatic write_count(logic [pdm_pkg::CNT_W-1:0] v);
        i_in_valid <= 1'b0;
        while (expected_beats.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        mix_count = v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Output side back-pressure, with quiet stretches where it never stalls
    initial begin
        int hold;
        hold = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                hold--;
            end else begin
                i_out_stall <= 1'b0;
                hold = quiet ? 0 : idle_len();
            end
        end
    end

    // Checker: each output beat against the oldest expectation
    always @(posedge i_clk) begin
        pdm_pkg::t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected beat byte=%h end=%b",
                             $realtime, o_out_data.packed_byte, o_out_data.end_marker);
            end else begin
                want = expected_beats.pop_front();
                if (o_out_data.packed_byte !== want.packed_byte) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: packed_byte expected %h got %h", $realtime,
                                 want.packed_byte, o_out_data.packed_byte);
                end
                if (o_out_data.end_marker !== want.end_marker) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: end_marker expected %b got %b", $realtime,
                                 want.end_marker, o_out_data.end_marker);
                end
            end
        end
    end

    initial begin
        int waited;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        i_cfg_we   = 1'b0;
        i_cfg_data = '0;
        mismatches = 0;
        quiet      = 1'b0;
        mix_count  = 4'd2;
        held_level = 4'h0;
        level_held = 1'b0;

        // Count 2 out of reset: full-scale levels, zero substitution,
        // lone final frames, and unused channels left at the rails.
        add_row(0, 0, make_frame( 32767,  32767,  32767, 0), 0, 8'h00);
        add_row(0, 0, make_frame(-32768, -32768, -32768, 0), 1, 8'h0F);
        add_row(0, 0, make_frame(-32768, -32768, -32768, 0), 0, 8'h00);
        add_row(0, 0, make_frame(-32768, -32768, -32768, 0), 1, 8'h11);
        add_row(0, 0, make_frame(-32768, -32768, -32768, 1), 1, 8'h11);
        add_row(0, 0, make_frame( 32767,  32767,  32767, 1), 1, 8'hFF);
        add_row(0, 0, make_frame( 32767, -32768,  32767, 0), 0, 8'h00);
        add_row(0, 0, make_frame(     0,      0, -32768, 1), 1, 8'h88);
        // Single channel
        add_row(1, 1, make_frame( 32767, -32768, -32768, 0), 0, 8'h00);
        add_row(0, 0, make_frame(     0,  32767,  32767, 1), 1, 8'h8F);
        // Count 0 behaves as one channel; -1 floors to the level below mid
        add_row(1, 0, make_frame(    -1,  32767,  32767, 0), 0, 8'h00);
        add_row(0, 0, make_frame(  4096, -32768, -32768, 1), 1, 8'h97);
        // Count 15 clamps to eight channels
        add_row(1, 15, make_frame( 32767,  32767, -32768, 0), 0, 8'h00);
        add_row(0, 0,  make_frame(-32768, -32768,  32767, 1), 0, 8'h00);
        add_row(1, 8,  make_frame( 32767,  32767,  32767, 1), 1, 8'hFF);
        // Count 3: the mean truncates toward zero before the level shift
        add_row(1, 3, make_frame(   -1,    -1,     0, 0), 0, 8'h00);
        add_row(0, 0, make_frame(-4097, -4097, -4097, 0), 0, 8'h00);
        add_row(0, 0, make_frame(    1,     1,     1, 1), 0, 8'h00);
        // Back to 2, around the level boundaries
        add_row(1, 2, make_frame( 4095,  4096, -32768, 0), 0, 8'h00);
        add_row(0, 0, make_frame(-4096, -4097,     -1, 1), 0, 8'h00);
        add_row(0, 0, make_frame(-4096,     0,      0, 0), 0, 8'h00);
        add_row(0, 0, make_frame(    0,     0,      0, 1), 0, 8'h00);

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[r]) begin
            if (directed_rows[r].wr_cfg)
                write_count(directed_rows[r].cfg_val);
            send_frame(directed_rows[r].frame, directed_rows[r].typed,
                       directed_rows[r].typed_byte);
        end

        // Random clips; each phase starts from a drained block with a new count
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0:       write_count(4'd1);
                1:       write_count(4'd8);
                2:       write_count(4'd0);
                3:       write_count(4'd15);
                default: write_count(4'($urandom_range(0, 15)));
            endcase
            for (int i = 0; i < PHASE_FRAMES; i++) begin
                if (i % 100 == 0)
                    quiet = ($urandom_range(0, 3) == 0);
                send_frame(random_frame(), 1'b0, 8'h00);
            end
        end
        i_in_valid <= 1'b0;
        quiet = 1'b0;

        // Drain, then give the pipe time to show any stray beat
        waited = 0;
        while (expected_beats.size() != 0 && waited < 100_000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && expected_beats.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
